/* rtl/cbxi_pkg.sv */
// Shared types and constants for the cubic Bezier x-inverse core.
package cbxi_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_BEFORE = 2'd0,
        ST_BEYOND = 2'd1,
        ST_TOL    = 2'd2,
        ST_LIMIT  = 2'd3
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SPLIT,
        S_MERGE,
        S_FINISH
    } t_state;

    // Configuration register indexes
    localparam logic CFG_TOLERANCE       = 1'b0;
    localparam logic CFG_ITERATION_LIMIT = 1'b1;

    localparam int TOL_WIDTH   = 16;
    localparam int LIMIT_WIDTH = 10;
    localparam logic [LIMIT_WIDTH-1:0] MAX_STEPS   = 10'd512;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 10'd32;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    split;
        logic    update;
        logic    emit;
        t_status code;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic at_start;
        logic past_end;
        logic hit;
    } t_dp_stat;

endpackage

/* rtl/cbxi_ctrl.sv */
// Sequencing state machine for the bisection: check, split/merge steps, finish.
module cbxi_ctrl (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [cbxi_pkg::LIMIT_WIDTH-1:0]    i_iteration_limit,
    input  cbxi_pkg::t_dp_stat                  i_stat,
    output cbxi_pkg::t_dp_cmd                   o_cmd,
    output logic                                busy
);

    cbxi_pkg::t_state r_state, n_state;
    logic [cbxi_pkg::LIMIT_WIDTH-1:0] r_step, n_step;
    logic [cbxi_pkg::LIMIT_WIDTH-1:0] w_lim;
    logic [cbxi_pkg::LIMIT_WIDTH-1:0] w_step_inc;
    logic w_edge_case;

    // Step limit saturates at the maximum
    assign w_lim = (i_iteration_limit > cbxi_pkg::MAX_STEPS) ?
                   cbxi_pkg::MAX_STEPS : i_iteration_limit;
    assign w_step_inc  = r_step + 1'b1;
    assign w_edge_case = i_stat.at_start || i_stat.past_end;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cbxi_pkg::S_IDLE: begin
                if (start) n_state = cbxi_pkg::S_CHECK;
            end
            cbxi_pkg::S_CHECK: begin
                if (w_edge_case)                          n_state = cbxi_pkg::S_IDLE;
                else if (w_lim == '0)                     n_state = cbxi_pkg::S_FINISH;
                else                                      n_state = cbxi_pkg::S_SPLIT;
            end
            cbxi_pkg::S_SPLIT:  n_state = cbxi_pkg::S_MERGE;
            cbxi_pkg::S_MERGE: begin
                if (i_stat.hit)                           n_state = cbxi_pkg::S_IDLE;
                else if (w_step_inc == w_lim)             n_state = cbxi_pkg::S_FINISH;
                else                                      n_state = cbxi_pkg::S_SPLIT;
            end
            cbxi_pkg::S_FINISH: n_state = cbxi_pkg::S_IDLE;
            default:            n_state = cbxi_pkg::S_IDLE;
        endcase
    end

    // Step counter
    always_comb begin
        n_step = r_step;
        if (r_state == cbxi_pkg::S_CHECK)                   n_step = '0;
        else if (r_state == cbxi_pkg::S_MERGE && !i_stat.hit) n_step = w_step_inc;
    end

    // Command decode
    always_comb begin
        o_cmd        = '0;
        o_cmd.code   = cbxi_pkg::ST_LIMIT;
        busy         = (r_state != cbxi_pkg::S_IDLE);
        case (r_state)
            cbxi_pkg::S_IDLE: begin
                o_cmd.load = start;
            end
            cbxi_pkg::S_CHECK: begin
                o_cmd.emit = w_edge_case;
                o_cmd.code = i_stat.at_start ? cbxi_pkg::ST_BEFORE : cbxi_pkg::ST_BEYOND;
            end
            cbxi_pkg::S_SPLIT: begin
                o_cmd.split = 1'b1;
            end
            cbxi_pkg::S_MERGE: begin
                o_cmd.update = !i_stat.hit;
                o_cmd.emit   = i_stat.hit;
                o_cmd.code   = cbxi_pkg::ST_TOL;
            end
            cbxi_pkg::S_FINISH: begin
                o_cmd.emit = 1'b1;
                o_cmd.code = cbxi_pkg::ST_LIMIT;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbxi_pkg::S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* rtl/cbxi_dpath.sv */
// Datapath: target-relative control points, de Casteljau split, t interval, result registers.
module cbxi_dpath #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cbxi_pkg::t_dp_cmd                   i_cmd,
    input  logic [cbxi_pkg::TOL_WIDTH-1:0]      i_tolerance,
    input  logic signed [COORD_WIDTH-1:0]       i_target_x,
    input  logic signed [COORD_WIDTH-1:0]       i_start_x,
    input  logic signed [COORD_WIDTH-1:0]       i_first_control_x,
    input  logic signed [COORD_WIDTH-1:0]       i_end_x,
    input  logic signed [COORD_WIDTH-1:0]       i_second_control_x,
    output cbxi_pkg::t_dp_stat                  o_stat,
    output logic                                o_valid,
    output logic [PARAM_FRAC_BITS:0]            o_curve_param,
    output logic [1:0]                          o_status
);

    // Points are held relative to the target; one extra bit holds the difference
    localparam int DW = COORD_WIDTH + 1;
    localparam int TW = PARAM_FRAC_BITS + 1;
    localparam logic [TW-1:0] T_ONE = TW'(1) << PARAM_FRAC_BITS;

    logic signed [DW-1:0] r_p0, r_c0, r_c1, r_p1;
    logic signed [DW-1:0] r_a, r_b, r_c, r_d, r_e;
    logic [TW-1:0]        r_u, r_v;
    logic                 r_valid;
    logic [TW-1:0]        r_curve_param;
    cbxi_pkg::t_status    r_status;

    logic signed [DW-1:0] w_a, w_b, w_c, w_d, w_e, w_f;
    logic signed [DW-1:0] w_tol;
    logic [TW:0]          w_tsum;
    logic [TW-1:0]        w_tmid;

    // Floor of the mean: arithmetic shift of the widened sum
    function automatic logic signed [DW-1:0] avg(input logic signed [DW-1:0] p,
                                                 input logic signed [DW-1:0] q);
        logic signed [DW:0] s;
        s = {p[DW-1], p} + {q[DW-1], q};
        return s[DW:1];
    endfunction

    // First split level: outer and second level averages
    assign w_a = avg(r_p0, r_c0);
    assign w_b = avg(r_c0, r_c1);
    assign w_c = avg(r_c1, r_p1);
    assign w_d = avg(w_a, w_b);
    assign w_e = avg(w_b, w_c);

    // Curve midpoint relative to target, and tolerance window
    assign w_f   = avg(r_d, r_e);
    assign w_tol = $signed({{(DW-cbxi_pkg::TOL_WIDTH){1'b0}}, i_tolerance});

    // Interval midpoint in t
    assign w_tsum = {1'b0, r_u} + {1'b0, r_v};
    assign w_tmid = w_tsum[TW:1];

    assign o_stat.at_start = (r_p0 >= 0);
    assign o_stat.past_end = (r_p1 <= 0);
    assign o_stat.hit      = (w_f <= w_tol) && (w_f >= -w_tol);

    // Point and interval registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p0 <= DW'(i_start_x)          - DW'(i_target_x);
            r_c0 <= DW'(i_first_control_x)  - DW'(i_target_x);
            r_c1 <= DW'(i_second_control_x) - DW'(i_target_x);
            r_p1 <= DW'(i_end_x)            - DW'(i_target_x);
            r_u  <= '0;
            r_v  <= T_ONE;
        end else if (i_cmd.update) begin
            if (w_f < 0) begin
                // Target lies in the right half
                r_p0 <= w_f;
                r_c0 <= r_e;
                r_c1 <= r_c;
                r_u  <= w_tmid;
            end else begin
                r_c0 <= r_a;
                r_c1 <= r_d;
                r_p1 <= w_f;
                r_v  <= w_tmid;
            end
        end
        if (i_cmd.split) begin
            r_a <= w_a;
            r_b <= w_b;
            r_c <= w_c;
            r_d <= w_d;
            r_e <= w_e;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status <= i_cmd.code;
            case (i_cmd.code)
                cbxi_pkg::ST_BEFORE: r_curve_param <= '0;
                cbxi_pkg::ST_BEYOND: r_curve_param <= T_ONE;
                default:             r_curve_param <= w_tmid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    assign o_valid       = r_valid;
    assign o_curve_param = r_curve_param;
    assign o_status      = r_status;

endmodule

/* rtl/cubic_bezier_x_inverse_core.sv */
// A target at or outside the end points is resolved in the check state that follows start.
// Otherwise each bisection step is a split state, then a merge state: a tolerance hit is
// emitted from the merge state of its step, reaching the step limit (max 512) from a finish state.
// One item at a time; a new start is taken in the cycle the result strobe is high.
// The result strobe lasts one cycle and cannot be stalled.
// Synchronous active-low reset: idle, no result pending, tolerance 0, iteration limit 32.
module cubic_bezier_x_inverse_core #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_idx,
    input  logic [cbxi_pkg::TOL_WIDTH-1:0]      i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       i_target_x,
    input  logic signed [COORD_WIDTH-1:0]       i_start_x,
    input  logic signed [COORD_WIDTH-1:0]       i_first_control_x,
    input  logic signed [COORD_WIDTH-1:0]       i_end_x,
    input  logic signed [COORD_WIDTH-1:0]       i_second_control_x,
    output logic                                o_valid,
    output logic [PARAM_FRAC_BITS:0]            o_curve_param,
    output logic [1:0]                          o_status
);

    logic [cbxi_pkg::TOL_WIDTH-1:0]   r_tolerance;
    logic [cbxi_pkg::LIMIT_WIDTH-1:0] r_iteration_limit;
    cbxi_pkg::t_dp_cmd                w_cmd;
    cbxi_pkg::t_dp_stat               w_stat;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance       <= '0;
            r_iteration_limit <= cbxi_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cbxi_pkg::CFG_TOLERANCE:       r_tolerance <= i_cfg_data;
                cbxi_pkg::CFG_ITERATION_LIMIT:
                    r_iteration_limit <= i_cfg_data[cbxi_pkg::LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    cbxi_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .i_iteration_limit (r_iteration_limit),
        .i_stat            (w_stat),
        .o_cmd             (w_cmd),
        .busy              (busy)
    );

    cbxi_dpath #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .i_tolerance        (r_tolerance),
        .i_target_x         (i_target_x),
        .i_start_x          (i_start_x),
        .i_first_control_x  (i_first_control_x),
        .i_end_x            (i_end_x),
        .i_second_control_x (i_second_control_x),
        .o_stat             (w_stat),
        .o_valid            (o_valid),
        .o_curve_param      (o_curve_param),
        .o_status           (o_status)
    );

    // A result beat is only shown once the controller has gone idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // An accepted start keeps the block busy in the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start accepted but block not busy");

    // t never leaves 0..1
    a_param_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_curve_param <= ((PARAM_FRAC_BITS+1)'(1) << PARAM_FRAC_BITS)))
        else $error("curve parameter above one");

    // Before-start results carry their fixed parameter value of zero
    a_edge_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == cbxi_pkg::ST_BEFORE)) |-> (o_curve_param == '0))
        else $error("before-start result with nonzero parameter");

endmodule

/* verif/tb_cubic_bezier_x_inverse_core.sv */
// Self-checking testbench for the cubic Bezier x-inverse core against a bisection predictor.
module tb_cubic_bezier_x_inverse_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int T_ONE     = 1 << FRAC_BITS;

    localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

    // One curve lookup request
    typedef struct {
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] first_ctrl_x;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] second_ctrl_x;
    } t_curve_item;

    // One solved parameter
    typedef struct {
        logic [FRAC_BITS:0] param;
        cbxi_pkg::t_status  status;
    } t_param_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_cfg_we = 1'b0;
    logic                                i_cfg_idx = cbxi_pkg::CFG_TOLERANCE;
    logic [cbxi_pkg::TOL_WIDTH-1:0]      i_cfg_data = '0;
    logic                                start = 1'b0;
    logic                                busy;
    logic signed [COORD_W-1:0]           i_target_x = '0;
    logic signed [COORD_W-1:0]           i_start_x = '0;
    logic signed [COORD_W-1:0]           i_first_control_x = '0;
    logic signed [COORD_W-1:0]           i_end_x = '0;
    logic signed [COORD_W-1:0]           i_second_control_x = '0;
    logic                                o_valid;
    logic [FRAC_BITS:0]                  o_curve_param;
    logic [1:0]                          o_status;

    t_curve_item   pending_curves[$];
    t_param_result expected_params[$];
    t_curve_item   cur_curve;
    logic          beat_taken = 1'b0;
    int            sender_idle_pct = 0;
    int            curves_queued = 0;
    int            results_seen = 0;
    int            errors = 0;

    // Register shadow copies used by the predictor
    logic [cbxi_pkg::TOL_WIDTH-1:0]   tol_cur = '0;
    logic [cbxi_pkg::LIMIT_WIDTH-1:0] lim_cur = cbxi_pkg::LIMIT_RESET;

    cubic_bezier_x_inverse_core #(
        .COORD_WIDTH     (COORD_W),
        .PARAM_FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .start              (start),
        .busy               (busy),
        .i_target_x         (i_target_x),
        .i_start_x          (i_start_x),
        .i_first_control_x  (i_first_control_x),
        .i_end_x            (i_end_x),
        .i_second_control_x (i_second_control_x),
        .o_valid            (o_valid),
        .o_curve_param      (o_curve_param),
        .o_status           (o_status)
    );

    always #10 i_clk = ~i_clk;

    // Bisection on de Casteljau midpoints, floor averages, truncated t midpoint
    function automatic t_param_result solve_curve_param(t_curve_item it,
            logic [cbxi_pkg::TOL_WIDTH-1:0] tol,
            logic [cbxi_pkg::LIMIT_WIDTH-1:0] lim);
        longint        tx, p0, c0, c1, p1, a, b, c, d, e, f, gap;
        int            t_lo, t_hi, steps;
        t_param_result r;
        tx = longint'(it.target_x);
        p0 = longint'(it.start_x);
        c0 = longint'(it.first_ctrl_x);
        p1 = longint'(it.end_x);
        c1 = longint'(it.second_ctrl_x);
        steps = (lim > cbxi_pkg::MAX_STEPS) ? int'(cbxi_pkg::MAX_STEPS) : int'(lim);
        t_lo = 0;
        t_hi = T_ONE;
        // before-start is tested first so it wins over beyond-end
        if (tx <= p0) begin
            r.param  = '0;
            r.status = cbxi_pkg::ST_BEFORE;
            return r;
        end
        if (p1 <= tx) begin
            r.param  = (FRAC_BITS+1)'(T_ONE);
            r.status = cbxi_pkg::ST_BEYOND;
            return r;
        end
        for (int k = 0; k < steps; k++) begin
            a = (p0 + c0) >>> 1;
            b = (c0 + c1) >>> 1;
            c = (c1 + p1) >>> 1;
            d = (a + b) >>> 1;
            e = (b + c) >>> 1;
            f = (d + e) >>> 1;
            gap = (f < tx) ? tx - f : f - tx;
            if (gap <= longint'(tol)) begin
                r.param  = (FRAC_BITS+1)'((t_lo + t_hi) >> 1);
                r.status = cbxi_pkg::ST_TOL;
                return r;
            end
            if (f < tx) begin
                p0   = f;
                c0   = e;
                c1   = c;
                t_lo = (t_lo + t_hi) >> 1;
            end else begin
                c0   = a;
                c1   = d;
                p1   = f;
                t_hi = (t_lo + t_hi) >> 1;
            end
        end
        r.param  = (FRAC_BITS+1)'((t_lo + t_hi) >> 1);
        r.status = cbxi_pkg::ST_LIMIT;
        return r;
    endfunction

    function automatic longint rand_coord();
        return longint'($signed($urandom));
    endfunction

    // Mostly targets strictly inside the end points, the rest raw noise
    function automatic t_curve_item rand_curve();
        t_curve_item it;
        longint      lo, hi, tmp, tx, span;
        int          sh;
        if ($urandom_range(99) < 80) begin
            sh = ($urandom_range(3) == 0) ? 0 : $urandom_range(24, 4);
            lo = rand_coord() >>> sh;
            hi = rand_coord() >>> sh;
            if (lo > hi) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            if (hi - lo < 2) begin
                lo = -1000;
                hi = 1000;
            end
            span = hi - lo - 1;
            case ($urandom_range(9))
                0: tx = lo + 1;
                1: tx = hi - 1;
                default: tx = lo + 1 + (longint'({32'd0, $urandom}) % span);
            endcase
            it.target_x = tx[COORD_W-1:0];
            it.start_x  = lo[COORD_W-1:0];
            it.end_x    = hi[COORD_W-1:0];
            // controls inside the hull most of the time, anywhere otherwise
            tmp = lo + (longint'({32'd0, $urandom}) % (hi - lo + 1));
            it.first_ctrl_x = ($urandom_range(3) != 0) ? tmp[COORD_W-1:0] : $urandom;
            tmp = lo + (longint'({32'd0, $urandom}) % (hi - lo + 1));
            it.second_ctrl_x = ($urandom_range(3) != 0) ? tmp[COORD_W-1:0] : $urandom;
        end else begin
            it.target_x      = $urandom;
            it.start_x       = $urandom;
            it.first_ctrl_x  = $urandom;
            it.end_x         = $urandom;
            it.second_ctrl_x = $urandom;
            case ($urandom_range(3))
                0: it.target_x = it.start_x;
                1: it.target_x = it.end_x;
                default: ;
            endcase
        end
        return it;
    endfunction

    task automatic add_curve(input logic signed [COORD_W-1:0] tx,
                             input logic signed [COORD_W-1:0] p0,
                             input logic signed [COORD_W-1:0] c0,
                             input logic signed [COORD_W-1:0] p1,
                             input logic signed [COORD_W-1:0] c1);
        t_curve_item it;
        it.target_x      = tx;
        it.start_x       = p0;
        it.first_ctrl_x  = c0;
        it.end_x         = p1;
        it.second_ctrl_x = c1;
        pending_curves.push_back(it);
        curves_queued++;
    endtask

    task automatic add_random_curves(input int n);
        repeat (n) begin
            pending_curves.push_back(rand_curve());
            curves_queued++;
        end
    endtask

    // Hold until every queued curve has produced its result
    task automatic wait_drained();
        while (results_seen != curves_queued) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [cbxi_pkg::TOL_WIDTH-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cbxi_pkg::CFG_TOLERANCE) tol_cur = data;
        else lim_cur = data[cbxi_pkg::LIMIT_WIDTH-1:0];
    endtask

    // Reconfigure while idle, run a batch, drain
    task automatic run_phase(input logic [cbxi_pkg::TOL_WIDTH-1:0] tol,
                             input logic [cbxi_pkg::TOL_WIDTH-1:0] lim, input int n);
        write_reg(cbxi_pkg::CFG_TOLERANCE, tol);
        write_reg(cbxi_pkg::CFG_ITERATION_LIMIT, lim);
        add_random_curves(n);
        wait_drained();
    endtask

    // Driver: present the next curve once the current beat is taken
    always @(negedge i_clk) begin
        t_curve_item nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || beat_taken) begin
            if (pending_curves.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt = pending_curves.pop_front();
                cur_curve          <= nxt;
                i_target_x         <= nxt.target_x;
                i_start_x          <= nxt.start_x;
                i_first_control_x  <= nxt.first_ctrl_x;
                i_end_x            <= nxt.end_x;
                i_second_control_x <= nxt.second_ctrl_x;
                start              <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check results in order, record the expectation of each accepted beat
    always @(posedge i_clk) begin
        t_param_result exp_r;
        if (i_rst_n) begin
            if (o_valid) begin
                results_seen++;
                if (expected_params.size() == 0) begin
                    $display("%0t: result with nothing expected: curve_param %0d status %0d",
                             $time, o_curve_param, o_status);
                    errors++;
                end else begin
                    exp_r = expected_params.pop_front();
                    if (o_curve_param !== exp_r.param) begin
                        $display("%0t: curve_param mismatch: expected %0d, actual %0d",
                                 $time, exp_r.param, o_curve_param);
                        errors++;
                    end
                    if (o_status !== exp_r.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, exp_r.status, o_status);
                        errors++;
                    end
                end
            end
            // beat_taken tells the driver whether this edge took the beat
            beat_taken <= start && !busy;
            if (start && !busy) begin
                expected_params.push_back(solve_curve_param(cur_curve, tol_cur, lim_cur));
            end
        end else begin
            beat_taken <= 1'b0;
        end
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset configuration (tolerance 0, limit 32)
        add_curve(0, 0, 0, 0, 0);                           // at start and at end: start wins
        add_curve(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);       // at start, most negative
        add_curve(-5, 10, 20, 30, 40);                      // before start
        add_curve(C_MAX, C_MIN, 0, C_MAX, 0);               // at end, full range
        add_curve(100, 0, 10, 50, 20);                      // beyond end
        add_curve(32768, 0, 21845, 65536, 43691);           // linear curve, mid target
        add_curve(0, C_MIN, C_MIN, C_MAX, C_MAX);           // extreme end points
        add_curve(C_MAX - 1, C_MIN, C_MAX, C_MAX, C_MIN);   // just inside the end
        add_curve(C_MIN + 1, C_MIN, C_MAX, C_MAX, C_MIN);   // just inside the start
        add_curve(40000, 0, -200000, 65536, 300000);        // non-monotone controls
        add_curve(1, 0, 0, 2, 0);                           // degenerate, tiny span
        add_curve(-1, -2, -2, 0, 0);
        add_curve(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, C_MAX, 32'shAAAA_AAAA);
        wait_drained();

        // Widest tolerance: first midpoint counts as a hit
        write_reg(cbxi_pkg::CFG_TOLERANCE, 16'hFFFF);
        add_curve(32768, 0, 21845, 65536, 43691);
        add_curve(0, C_MIN, C_MIN, C_MAX, C_MAX);
        wait_drained();

        // Zero iteration limit: half the interval without a step, end-point results unchanged
        write_reg(cbxi_pkg::CFG_ITERATION_LIMIT, 16'd0);
        add_curve(32768, 0, 21845, 65536, 43691);
        add_curve(0, 0, 0, 0, 0);
        add_curve(100, 0, 10, 50, 20);
        wait_drained();

        // Limits at and above the step cap, with tolerance 0 and then 3
        write_reg(cbxi_pkg::CFG_TOLERANCE, 16'd0);
        write_reg(cbxi_pkg::CFG_ITERATION_LIMIT, 16'hFFFF);
        add_curve(32768, 0, 21845, 65536, 43691);
        add_random_curves(4);
        wait_drained();
        run_phase(16'd0, 16'd512, 4);
        run_phase(16'd3, 16'd513, 2);

        // Sender idles about a third of the time
        sender_idle_pct = 32;
        run_phase(16'd0, 16'd32, 100);
        run_phase(16'($urandom_range(255)), 16'($urandom_range(24, 1)), 100);
        run_phase(16'hFFFF, 16'd1, 100);
        run_phase(16'($urandom), 16'($urandom_range(40, 1)), 100);

        // Sender idles about half the time
        sender_idle_pct = 52;
        run_phase(16'($urandom_range(15)), 16'($urandom_range(40, 1)), 100);
        run_phase(16'($urandom), 16'd0, 50);
        run_phase(16'($urandom_range(1023)), 16'($urandom_range(40, 1)), 100);

        // Back-to-back beats
        sender_idle_pct = 0;
        run_phase(16'd0, 16'($urandom_range(40, 1)), 100);
        run_phase(16'($urandom), 16'($urandom_range(40, 1)), 100);

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
